>>> hw/rtl/isilu_pkg.sv
// ----------------------------------------------------------------------------
// isilu_pkg: shared types and constants of the int8 SiLU pipeline
// Fixed-point constants, register codes and the structs that travel between
// the pipeline sections.
// ----------------------------------------------------------------------------
package isilu_pkg;

  // fixed-point constants
  localparam logic [63:0] ONE60         = 64'h1000_0000_0000_0000;  // 1.0 in Q60
  localparam logic [63:0] LN2_Q60       = 64'h0B17_217F_7D1C_F79B;  // ln 2 in Q60
  localparam logic [38:0] SAT_LIMIT_Q24 = 39'h00_0C00_0000;         // 12.0 in Q24
  localparam int unsigned TAYLOR_TERMS  = 25;
  localparam int unsigned SIG_STEPS     = 17;                       // quotient bits
  localparam logic [16:0] SIG_ONE       = 17'h1_0000;               // 1.0 in Q0.16

  // register indexes
  localparam logic [1:0] REG_INPUT_SCALE  = 2'd0;
  localparam logic [1:0] REG_OUTPUT_RECIP = 2'd1;
  localparam logic [1:0] REG_CLAMP_LOW    = 2'd2;
  localparam logic [1:0] REG_CLAMP_HIGH   = 2'd3;

  // register reset values
  localparam logic [31:0]        RST_INPUT_SCALE  = 32'h0100_0000;
  localparam logic [31:0]        RST_OUTPUT_RECIP = 32'h0001_0000;
  localparam logic signed [7:0]  RST_CLAMP_LOW    = -8'sd128;
  localparam logic signed [7:0]  RST_CLAMP_HIGH   = 8'sd127;

  // configuration registers as seen by the datapath
  typedef struct packed {
    logic [31:0]       input_scale;
    logic [31:0]       output_recip;
    logic signed [7:0] clamp_low;
    logic signed [7:0] clamp_high;
  } cfg_t;

  // per-word context after dequantization and range reduction
  typedef struct packed {
    logic        neg;    // input was negative
    logic        sat;    // |f| >= 12, sigmoid saturates
    logic [38:0] fmag;   // |f| in Q24
    logic [4:0]  k;      // ln2 multiples removed
    logic [59:0] r;      // reduced argument in Q60
  } ctx_t;

  // Taylor series state
  typedef struct packed {
    logic [60:0] term;
    logic [63:0] sum;
  } exp_t;

  // sigmoid result with what the back end still needs
  typedef struct packed {
    logic        neg;
    logic [38:0] fmag;
    logic [16:0] s;      // sigmoid in Q0.16
  } sig_t;

endpackage

>>> hw/rtl/isilu_cfg.sv
// ----------------------------------------------------------------------------
// isilu_cfg: configuration register file
// APB-style slave holding the scale, reciprocal and clamp registers.
// ----------------------------------------------------------------------------
module isilu_cfg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output isilu_pkg::cfg_t    cfg
);

  isilu_pkg::cfg_t cfg_r;
  logic [1:0]      idx;
  logic            wr;

  assign idx    = paddr[3:2];
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.input_scale  <= isilu_pkg::RST_INPUT_SCALE;
      cfg_r.output_recip <= isilu_pkg::RST_OUTPUT_RECIP;
      cfg_r.clamp_low    <= isilu_pkg::RST_CLAMP_LOW;
      cfg_r.clamp_high   <= isilu_pkg::RST_CLAMP_HIGH;
    end else if (wr) begin
      case (idx)
        isilu_pkg::REG_INPUT_SCALE:  cfg_r.input_scale  <= pwdata;
        isilu_pkg::REG_OUTPUT_RECIP: cfg_r.output_recip <= pwdata;
        isilu_pkg::REG_CLAMP_LOW:    cfg_r.clamp_low    <= $signed(pwdata[7:0]);
        isilu_pkg::REG_CLAMP_HIGH:   cfg_r.clamp_high   <= $signed(pwdata[7:0]);
        default: ;
      endcase
    end
  end

  // read back, clamps sign extended
  always_comb begin
    case (idx)
      isilu_pkg::REG_INPUT_SCALE:  prdata = cfg_r.input_scale;
      isilu_pkg::REG_OUTPUT_RECIP: prdata = cfg_r.output_recip;
      isilu_pkg::REG_CLAMP_LOW:    prdata = {{24{cfg_r.clamp_low[7]}}, cfg_r.clamp_low};
      isilu_pkg::REG_CLAMP_HIGH:   prdata = {{24{cfg_r.clamp_high[7]}}, cfg_r.clamp_high};
      default:                     prdata = 32'd0;
    endcase
  end

endmodule

>>> hw/rtl/isilu_front.sv
// ----------------------------------------------------------------------------
// isilu_front: dequantization and range reduction
// Five stages: input register, |x| * input_scale, then the argument is
// reduced by multiples of ln 2, two quotient bits per stage and one in the last.
// ----------------------------------------------------------------------------
module isilu_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              i_vld,
  input  logic signed [7:0] i_value,
  input  logic [31:0]       input_scale,
  output logic              o_vld,
  output isilu_pkg::ctx_t   o_ctx
);

  localparam logic [63:0] D4 = isilu_pkg::LN2_Q60 << 4;
  localparam logic [63:0] D3 = isilu_pkg::LN2_Q60 << 3;
  localparam logic [63:0] D2 = isilu_pkg::LN2_Q60 << 2;
  localparam logic [63:0] D1 = isilu_pkg::LN2_Q60 << 1;
  localparam logic [63:0] D0 = isilu_pkg::LN2_Q60;

  // one restoring step: {quotient bit, remainder}
  function automatic logic [64:0] red_step(input logic [63:0] rem, input logic [63:0] dv);
    logic [64:0] res;
    if (rem >= dv) res = {1'b1, rem - dv};
    else           res = {1'b0, rem};
    return res;
  endfunction

  logic              v0_r, v1_r, v2_r, v3_r, v4_r;
  logic signed [7:0] x_r;
  logic              neg1_r;
  logic [38:0]       fmag1_r;
  logic              neg2_r, sat2_r, neg3_r, sat3_r;
  logic [38:0]       fmag2_r, fmag3_r;
  logic [63:0]       rem2_r, rem3_r;
  logic [1:0]        k2_r;
  logic [3:0]        k3_r;
  isilu_pkg::ctx_t   ctx_r;

  logic [7:0]        xm;
  logic [38:0]       fmag1_nxt;
  logic [64:0]       s4, s3, s2, s1, s0;

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v0_r <= i_vld;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // magnitude times scale, Q24
  always_comb begin
    xm        = x_r[7] ? 8'(-x_r) : 8'(x_r);
    fmag1_nxt = 39'(xm) * 39'(input_scale);
  end

  // reduction steps, the remainder starts as |f| in Q60
  always_comb begin
    s4 = red_step({fmag1_r[27:0], 36'd0}, D4);
    s3 = red_step(s4[63:0], D3);
    s2 = red_step(rem2_r, D2);
    s1 = red_step(s2[63:0], D1);
    s0 = red_step(rem3_r, D0);
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (en) begin
      x_r     <= i_value;
      neg1_r  <= x_r[7];
      fmag1_r <= fmag1_nxt;
      neg2_r  <= neg1_r;
      sat2_r  <= fmag1_r >= isilu_pkg::SAT_LIMIT_Q24;
      fmag2_r <= fmag1_r;
      rem2_r  <= s3[63:0];
      k2_r    <= {s4[64], s3[64]};
      neg3_r  <= neg2_r;
      sat3_r  <= sat2_r;
      fmag3_r <= fmag2_r;
      rem3_r  <= s1[63:0];
      k3_r    <= {k2_r, s2[64], s1[64]};
      ctx_r.neg  <= neg3_r;
      ctx_r.sat  <= sat3_r;
      ctx_r.fmag <= fmag3_r;
      ctx_r.k    <= {k3_r, s0[64]};
      ctx_r.r    <= s0[59:0];
    end
  end

  assign o_vld = v4_r;
  assign o_ctx = ctx_r;

endmodule

>>> hw/rtl/isilu_term.sv
// ----------------------------------------------------------------------------
// isilu_term: one Taylor term of exp(-r)
// term <- floor((term * r) >> 60) / N, sum <- sum -/+ term.
// Split products, then a reciprocal multiply with one correction for the
// division by N. Three stages for N = 1, six otherwise.
// ----------------------------------------------------------------------------
module isilu_term #(
  parameter int unsigned N = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            i_vld,
  input  isilu_pkg::ctx_t i_ctx,
  input  isilu_pkg::exp_t i_exp,
  output logic            o_vld,
  output isilu_pkg::ctx_t o_ctx,
  output isilu_pkg::exp_t o_exp
);

  // stage A: partial products of term * r
  logic            a_vld_r;
  isilu_pkg::ctx_t a_ctx_r;
  logic [63:0]     a_sum_r;
  logic [63:0]     a_pll_r;
  logic [59:0]     a_plh_r;
  logic [60:0]     a_phl_r;
  logic [56:0]     a_phh_r;

  // stage B: (term * r) >> 60
  logic            b_vld_r;
  isilu_pkg::ctx_t b_ctx_r;
  logic [63:0]     b_sum_r;
  logic [59:0]     b_p_r;
  logic [120:0]    b_prod;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= i_vld;
      b_vld_r <= a_vld_r;
    end
  end

  assign b_prod = {57'd0, a_pll_r} + {29'd0, a_plh_r, 32'd0} + {28'd0, a_phl_r, 32'd0}
                + {a_phh_r, 64'd0};

  always_ff @(posedge clk) begin
    if (en) begin
      a_ctx_r <= i_ctx;
      a_sum_r <= i_exp.sum;
      a_pll_r <= 64'(i_exp.term[31:0])  * 64'(i_ctx.r[31:0]);
      a_plh_r <= 60'(i_exp.term[31:0])  * 60'(i_ctx.r[59:32]);
      a_phl_r <= 61'(i_exp.term[60:32]) * 61'(i_ctx.r[31:0]);
      a_phh_r <= 57'(i_exp.term[60:32]) * 57'(i_ctx.r[59:32]);
      b_ctx_r <= a_ctx_r;
      b_sum_r <= a_sum_r;
      b_p_r   <= b_prod[119:60];
    end
  end

  if (N == 1) begin : g_one
    // no division, straight to the sum update
    logic            u_vld_r;
    isilu_pkg::ctx_t u_ctx_r;
    isilu_pkg::exp_t u_exp_r;

    always_ff @(posedge clk) begin
      if (!rst_n) u_vld_r <= 1'b0;
      else if (en) u_vld_r <= b_vld_r;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        u_ctx_r      <= b_ctx_r;
        u_exp_r.term <= {1'b0, b_p_r};
        u_exp_r.sum  <= ((N % 2) == 1) ? b_sum_r - {4'd0, b_p_r} : b_sum_r + {4'd0, b_p_r};
      end
    end

    assign o_vld = u_vld_r;
    assign o_ctx = u_ctx_r;
    assign o_exp = u_exp_r;
  end else begin : g_div
    // floor(2^64 / N), the estimate is at most one below the quotient
    localparam logic [63:0] RECIP = 64'((65'd1 << 64) / 65'(N));

    logic            c_vld_r, d_vld_r, e_vld_r, u_vld_r;
    isilu_pkg::ctx_t c_ctx_r, d_ctx_r, e_ctx_r, u_ctx_r;
    logic [63:0]     c_sum_r, d_sum_r, e_sum_r;
    logic [59:0]     c_p_r, d_p_r;
    logic [63:0]     c_ll_r, c_lh_r;
    logic [59:0]     c_hl_r, c_hh_r;
    logic [123:0]    d_prod;
    logic [59:0]     d_q0_r, e_q0_r;
    logic [63:0]     e_rem;
    logic            e_corr_r;
    logic [59:0]     u_q;
    isilu_pkg::exp_t u_exp_r;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        c_vld_r <= 1'b0;
        d_vld_r <= 1'b0;
        e_vld_r <= 1'b0;
        u_vld_r <= 1'b0;
      end else if (en) begin
        c_vld_r <= b_vld_r;
        d_vld_r <= c_vld_r;
        e_vld_r <= d_vld_r;
        u_vld_r <= e_vld_r;
      end
    end

    assign d_prod = {60'd0, c_ll_r} + {28'd0, c_lh_r, 32'd0} + {32'd0, c_hl_r, 32'd0}
                  + {c_hh_r, 64'd0};
    assign e_rem  = {4'd0, d_p_r} - 64'(d_q0_r) * 64'(N);
    assign u_q    = e_q0_r + 60'(e_corr_r);

    always_ff @(posedge clk) begin
      if (en) begin
        // stage C: partial products of p * RECIP
        c_ctx_r <= b_ctx_r;
        c_sum_r <= b_sum_r;
        c_p_r   <= b_p_r;
        c_ll_r  <= 64'(b_p_r[31:0])  * 64'(RECIP[31:0]);
        c_lh_r  <= 64'(b_p_r[31:0])  * 64'(RECIP[63:32]);
        c_hl_r  <= 60'(b_p_r[59:32]) * 60'(RECIP[31:0]);
        c_hh_r  <= 60'(b_p_r[59:32]) * 60'(RECIP[63:32]);
        // stage D: quotient estimate
        d_ctx_r <= c_ctx_r;
        d_sum_r <= c_sum_r;
        d_p_r   <= c_p_r;
        d_q0_r  <= d_prod[123:64];
        // stage E: correction bit from the remainder
        e_ctx_r  <= d_ctx_r;
        e_sum_r  <= d_sum_r;
        e_q0_r   <= d_q0_r;
        e_corr_r <= e_rem >= 64'(N);
        // stage U: new term, sum update
        u_ctx_r      <= e_ctx_r;
        u_exp_r.term <= {1'b0, u_q};
        u_exp_r.sum  <= ((N % 2) == 1) ? e_sum_r - {4'd0, u_q} : e_sum_r + {4'd0, u_q};
      end
    end

    assign o_vld = u_vld_r;
    assign o_ctx = u_ctx_r;
    assign o_exp = u_exp_r;
  end

endmodule

>>> hw/rtl/isilu_sigdiv.sv
// ----------------------------------------------------------------------------
// isilu_sigdiv: sigmoid from exp(-|f|)
// e = sum >> k, then num / (1 + e) by restoring division, one quotient bit
// per stage, and round to 16 fractional bits. Saturated words are forced.
// ----------------------------------------------------------------------------
module isilu_sigdiv (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            i_vld,
  input  isilu_pkg::ctx_t i_ctx,
  input  isilu_pkg::exp_t i_exp,
  output logic            o_vld,
  output isilu_pkg::sig_t o_sig
);

  localparam int unsigned STEPS = isilu_pkg::SIG_STEPS;

  typedef struct packed {
    logic        neg;
    logic        sat;
    logic [38:0] fmag;
    logic [61:0] den;
    logic [61:0] rem;
    logic [17:0] q;
  } div_t;

  div_t            stg_r [0:STEPS];
  logic [STEPS:0]  vld_r;
  isilu_pkg::sig_t sig_r;
  logic            sig_vld_r;

  logic [63:0]     e;
  logic [61:0]     den;
  logic [60:0]     num;
  logic            q0;
  logic [18:0]     q_rnd;

  // first stage: exponent shift, denominator and integer quotient bit
  always_comb begin
    e   = i_exp.sum >> i_ctx.k;
    den = 62'(isilu_pkg::ONE60) + e[61:0];
    num = i_ctx.neg ? e[60:0] : isilu_pkg::ONE60[60:0];
    q0  = {1'b0, num} >= den;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r[0] <= 1'b0;
    else if (en) vld_r[0] <= i_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg_r[0].neg  <= i_ctx.neg;
      stg_r[0].sat  <= i_ctx.sat;
      stg_r[0].fmag <= i_ctx.fmag;
      stg_r[0].den  <= den;
      stg_r[0].rem  <= {1'b0, num} - (q0 ? den : 62'd0);
      stg_r[0].q    <= {17'd0, q0};
    end
  end

  // restoring division stages
  for (genvar i = 1; i <= STEPS; i++) begin : g_step
    logic [62:0] rem2;
    logic        ge;
    div_t        stg_nxt;

    always_comb begin
      rem2        = {stg_r[i-1].rem, 1'b0};
      ge          = rem2 >= {1'b0, stg_r[i-1].den};
      stg_nxt     = stg_r[i-1];
      stg_nxt.rem = ge ? 62'(rem2 - {1'b0, stg_r[i-1].den}) : rem2[61:0];
      stg_nxt.q   = {stg_r[i-1].q[16:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[i] <= 1'b0;
      else if (en) vld_r[i] <= vld_r[i-1];
    end

    always_ff @(posedge clk) begin
      if (en) stg_r[i] <= stg_nxt;
    end
  end

  // round half up to Q0.16, saturation overrides
  assign q_rnd = 19'(stg_r[STEPS].q) + 19'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) sig_vld_r <= 1'b0;
    else if (en) sig_vld_r <= vld_r[STEPS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sig_r.neg  <= stg_r[STEPS].neg;
      sig_r.fmag <= stg_r[STEPS].fmag;
      if (stg_r[STEPS].sat) sig_r.s <= stg_r[STEPS].neg ? 17'd0 : isilu_pkg::SIG_ONE;
      else                  sig_r.s <= q_rnd[17:1];
    end
  end

  assign o_vld = sig_vld_r;
  assign o_sig = sig_r;

endmodule

>>> hw/rtl/int8_silu_activation.sv
// ----------------------------------------------------------------------------
// int8_silu_activation: quantized SiLU on signed 8-bit words
// Dequantize, x * sigmoid(x) in fixed point, scale, round and clamp.
// ----------------------------------------------------------------------------
// The block takes and returns one word per clock unless held by out_stall.
// Each word goes through a fixed chain of 175 register stages from in_value
// to out_value: 5 for dequantization and ln 2 range reduction, 147 for the
// 25 Taylor terms of exp(-r) (three stages for the first term, six for each
// of the others), 19 for the sigmoid division (one quotient bit per stage,
// then rounding) and 4 for the SiLU product, output scaling, rounding and
// clamping. All stages advance together; a result waiting under out_stall
// holds the whole chain and raises in_stall. The user must write registers
// through the APB port only while no word is in flight; it is not enforced.
module int8_silu_activation (
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic signed [7:0] in_value,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [7:0] out_value,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int unsigned TERMS = isilu_pkg::TAYLOR_TERMS;

  isilu_pkg::cfg_t cfg;
  logic            en;

  logic [TERMS:0]  t_vld;
  isilu_pkg::ctx_t t_ctx [0:TERMS];
  isilu_pkg::exp_t t_exp [0:TERMS];

  logic            sig_vld;
  isilu_pkg::sig_t sig;

  logic              y_vld_r, z_vld_r, q_vld_r, out_valid_r;
  logic              y_neg_r, z_neg_r;
  logic [31:0]       y_mag_r;
  logic [63:0]       z_mag_r;
  logic signed [33:0] q_r;
  logic signed [7:0] out_value_r;

  logic [56:0]        y_rnd;
  logic [64:0]        z_rnd;
  logic signed [33:0] q_nxt, lo, hi, qc;
  logic signed [7:0]  out_value_nxt;

  // the whole chain moves unless a finished word is held at the output
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  isilu_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  isilu_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .i_vld       (in_valid),
    .i_value     (in_value),
    .input_scale (cfg.input_scale),
    .o_vld       (t_vld[0]),
    .o_ctx       (t_ctx[0])
  );

  // series starts at term = sum = 1.0
  assign t_exp[0].term = isilu_pkg::ONE60[60:0];
  assign t_exp[0].sum  = isilu_pkg::ONE60;

  for (genvar i = 0; i < TERMS; i++) begin : g_term
    isilu_term #(
      .N (i + 1)
    ) u_term (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .i_vld (t_vld[i]),
      .i_ctx (t_ctx[i]),
      .i_exp (t_exp[i]),
      .o_vld (t_vld[i+1]),
      .o_ctx (t_ctx[i+1]),
      .o_exp (t_exp[i+1])
    );
  end

  isilu_sigdiv u_sigdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .i_vld (t_vld[TERMS]),
    .i_ctx (t_ctx[TERMS]),
    .i_exp (t_exp[TERMS]),
    .o_vld (sig_vld),
    .o_sig (sig)
  );

  // back end arithmetic
  always_comb begin
    y_rnd = 57'(sig.fmag) * 57'(sig.s) + (57'd1 << 23);
    z_rnd = {1'b0, z_mag_r} + (65'd1 << 31);
    q_nxt = z_neg_r ? -$signed({1'b0, z_rnd[64:32]}) : $signed({1'b0, z_rnd[64:32]});
    // low bound first, high bound last
    lo = 34'(cfg.clamp_low);
    hi = 34'(cfg.clamp_high);
    qc = q_r;
    if (qc < lo) qc = lo;
    if (qc > hi) qc = hi;
    out_value_nxt = qc[7:0];
  end

  // valid chain of the back end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      y_vld_r     <= 1'b0;
      z_vld_r     <= 1'b0;
      q_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      y_vld_r     <= sig_vld;
      z_vld_r     <= y_vld_r;
      q_vld_r     <= z_vld_r;
      out_valid_r <= q_vld_r;
    end
  end

  // y = f * s in Q16, z = y * recip in Q32, q rounded, then clamped
  always_ff @(posedge clk) begin
    if (en) begin
      y_neg_r     <= sig.neg;
      y_mag_r     <= y_rnd[55:24];
      z_neg_r     <= y_neg_r;
      z_mag_r     <= 64'(y_mag_r) * 64'(cfg.output_recip);
      q_r         <= q_nxt;
      out_value_r <= out_value_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

  // range reduction leaves k and r in range for unsaturated words
  a_reduce_bound: assert property (@(posedge clk) disable iff (!rst_n)
    t_vld[0] && !t_ctx[0].sat |->
      (t_ctx[0].k <= 5'd17) && (64'(t_ctx[0].r) < isilu_pkg::LN2_Q60))
    else $error("range reduction out of bounds");

  // sigmoid never exceeds one
  a_sig_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sig_vld |-> sig.s <= isilu_pkg::SIG_ONE)
    else $error("sigmoid above 1.0");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for int8_silu_activation
// Streams signed 8-bit words through the SiLU pipeline under random sender
// gaps and receiver stalls. Every accepted word is run through a bit-exact
// fixed-point SiLU predictor and checked in order against the result channel.
// Registers are rewritten over the APB port between phases, once the pipeline
// has drained.
// ----------------------------------------------------------------------------
module tb_top;

  // predictor constants, kept local so the check does not lean on the RTL
  localparam logic [63:0] FIX60_ONE   = 64'h1000_0000_0000_0000;
  localparam logic [63:0] FIX60_LN2   = 64'h0B17_217F_7D1C_F79B;
  localparam logic [63:0] EXP_SAT_Q24 = 64'd12 << 24;
  localparam int          EXP_TERMS   = 25;
  localparam int          DIV_BITS    = 17;
  localparam int          RUN_LIMIT   = 400000;
  localparam int          TAIL_CYCLES = 400;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic signed [7:0] in_value;
  logic              out_valid;
  logic              out_stall;
  logic signed [7:0] out_value;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [3:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  // predictor copy of the registers
  logic [31:0]       silu_in_scale;
  logic [31:0]       silu_out_recip;
  logic signed [7:0] silu_clamp_lo;
  logic signed [7:0] silu_clamp_hi;

  logic signed [7:0] pending_words[$];
  logic signed [7:0] expected_words[$];
  int                fail_count;
  int                cycle_count;
  int                send_idle_pct;
  int                recv_stall_pct;

  int8_silu_activation dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_value  (in_value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_value (out_value),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // (a * b) >> 60, full product
  function automatic logic [63:0] mul_fix60(logic [63:0] a, logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[123:60];
  endfunction

  // exp(-t) in Q60 for t in Q24 below the saturation point
  function automatic logic [63:0] exp_neg_fix60(logic [63:0] t24);
    logic [63:0] t60, k, r, term, sum;
    t60  = t24 << 36;
    k    = t60 / FIX60_LN2;
    r    = t60 - k * FIX60_LN2;
    term = FIX60_ONE;
    sum  = FIX60_ONE;
    for (int n = 1; n <= EXP_TERMS; n++) begin
      term = mul_fix60(term, r) / 64'(n);
      if (n % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    if (k > 63) begin
      return 64'd0;
    end
    return sum >> k;
  endfunction

  // sigmoid in Q0.16, rounded to nearest, by restoring division
  function automatic logic [16:0] sigmoid_fix16(logic neg, logic [63:0] t24);
    logic [63:0] e, den, rem, quo;
    if (t24 >= EXP_SAT_Q24) begin
      return neg ? 17'd0 : 17'h1_0000;
    end
    e   = exp_neg_fix60(t24);
    den = FIX60_ONE + e;
    rem = neg ? e : FIX60_ONE;
    quo = rem / den;
    rem = rem - quo * den;
    for (int i = 0; i < DIV_BITS; i++) begin
      rem = rem << 1;
      quo = quo << 1;
      if (rem >= den) begin
        rem = rem - den;
        quo = quo | 64'd1;
      end
    end
    return 17'((quo + 64'd1) >> 1);
  endfunction

  // quantized SiLU of one word under the current registers
  function automatic logic signed [7:0] silu_predict(logic signed [7:0] x);
    logic        neg;
    logic [63:0] xmag, fmag, ymag, zmag, qmag;
    logic [16:0] sg;
    longint      q;
    neg  = x[7];
    xmag = neg ? 64'(-int'(x)) : 64'(int'(x));
    fmag = xmag * {32'd0, silu_in_scale};
    sg   = sigmoid_fix16(neg, fmag);
    ymag = (fmag * {47'd0, sg} + 64'h0080_0000) >> 24;
    zmag = ymag * {32'd0, silu_out_recip};
    qmag = (zmag + 64'h8000_0000) >> 32;
    q    = neg ? -longint'(qmag) : longint'(qmag);
    // low bound first, high bound wins when they cross
    if (q < longint'(silu_clamp_lo)) q = longint'(silu_clamp_lo);
    if (q > longint'(silu_clamp_hi)) q = longint'(silu_clamp_hi);
    return 8'(q);
  endfunction

  // APB write: setup, then access until pready
  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      isilu_pkg::REG_INPUT_SCALE:  silu_in_scale  = data;
      isilu_pkg::REG_OUTPUT_RECIP: silu_out_recip = data;
      isilu_pkg::REG_CLAMP_LOW:    silu_clamp_lo  = data[7:0];
      isilu_pkg::REG_CLAMP_HIGH:   silu_clamp_hi  = data[7:0];
      default: ;
    endcase
  endtask

  task automatic cfg_write_all(input logic [31:0] scale, input logic [31:0] recip,
                               input logic signed [7:0] lo, input logic signed [7:0] hi);
    cfg_write(isilu_pkg::REG_INPUT_SCALE, scale);
    cfg_write(isilu_pkg::REG_OUTPUT_RECIP, recip);
    cfg_write(isilu_pkg::REG_CLAMP_LOW, {24'd0, lo});
    cfg_write(isilu_pkg::REG_CLAMP_HIGH, {24'd0, hi});
  endtask

  // hold the sender until every word has come back out; sampled between
  // edges so the driver's and checker's updates have settled
  task automatic wait_for_drain();
    @(negedge clk);
    while (pending_words.size() > 0 || in_valid || expected_words.size() > 0)
      @(negedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic pick_random_config();
    logic [31:0]       scale, recip;
    logic signed [7:0] lo, hi;
    case ($urandom_range(7))
      0:       scale = 32'hFFFF_FFFF;
      1:       scale = 32'd0;
      2, 3:    scale = $urandom;
      default: scale = $urandom_range(32'h0200_0000);
    endcase
    case ($urandom_range(5))
      0:       recip = 32'hFFFF_FFFF;
      1:       recip = 32'd0;
      2:       recip = $urandom;
      default: recip = $urandom_range(32'h0040_0000);
    endcase
    case ($urandom_range(3))
      0, 1: begin
        lo = -8'sd128;
        hi = 8'sd127;
      end
      2: begin
        // any pair, crossed bounds included
        lo = 8'($urandom_range(255));
        hi = 8'($urandom_range(255));
      end
      default: begin
        lo = -8'sd128 + 8'($urandom_range(128));
        hi = 8'($urandom_range(127));
      end
    endcase
    cfg_write_all(scale, recip, lo, hi);
  endtask

  function automatic logic signed [7:0] random_word();
    case ($urandom_range(7))
      0: begin
        case ($urandom_range(5))
          0:       return -8'sd128;
          1:       return -8'sd127;
          2:       return -8'sd1;
          3:       return 8'sd0;
          4:       return 8'sd1;
          default: return 8'sd127;
        endcase
      end
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // sender: holds the word while stalled, draws the next after acceptance
  always @(posedge clk) begin : word_driver
    logic take;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_words.push_back(silu_predict(in_value));
      if (!in_valid || !in_stall) begin
        take = pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct;
        in_valid <= take;
        if (take) in_value <= pending_words.pop_front();
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= $urandom_range(99) < recv_stall_pct;
    end
  end

  // result checker
  always @(posedge clk) begin : word_checker
    logic signed [7:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        $error("out_value: no word expected, actual %0d", out_value);
        fail_count++;
      end else begin
        want = expected_words.pop_front();
        if (out_value !== want) begin
          $error("out_value mismatch: expected %0d, actual %0d", want, out_value);
          fail_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    fail_count     = 0;
    cycle_count    = 0;
    send_idle_pct  = 24;
    recv_stall_pct = 64;
    silu_in_scale  = 32'h0100_0000;
    silu_out_recip = 32'h0001_0000;
    silu_clamp_lo  = -8'sd128;
    silu_clamp_hi  = 8'sd127;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_value  <= 8'sd0;
    out_stall <= 1'b0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= 4'd0;
    pwdata    <= 32'd0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // reset registers: field extremes and both signs
    pending_words = '{-8'sd128, -8'sd1, 8'sd0, 8'sd1, 8'sd127, 8'sd64, -8'sd64};
    wait_for_drain();

    // zero input scale
    cfg_write_all(32'd0, 32'hFFFF_FFFF, -8'sd128, 8'sd127);
    pending_words = '{-8'sd128, 8'sd127, 8'sd5};
    wait_for_drain();

    // zero reciprocal
    cfg_write_all(32'hFFFF_FFFF, 32'd0, -8'sd128, 8'sd127);
    pending_words = '{-8'sd128, 8'sd127};
    wait_for_drain();

    // largest products, well past the int8 range before clamping
    cfg_write(isilu_pkg::REG_OUTPUT_RECIP, 32'hFFFF_FFFF);
    pending_words = '{-8'sd128, 8'sd127, -8'sd1, 8'sd1};
    wait_for_drain();

    // crossed clamp bounds
    cfg_write_all(32'h0100_0000, 32'h0001_0000, 8'sd50, -8'sd50);
    pending_words = '{8'sd0, 8'sd100, -8'sd100};
    wait_for_drain();

    // random phases: heavy receiver stalls, then a sparse sender, then free running
    for (int phase = 0; phase < 6; phase++) begin
      if (phase < 2) begin
        send_idle_pct  = 24;
        recv_stall_pct = 64;
      end else if (phase < 4) begin
        send_idle_pct  = 64;
        recv_stall_pct = 24;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      for (int set = 0; set < 3; set++) begin
        pick_random_config();
        @(negedge clk);
        for (int i = 0; i < 75; i++) pending_words.push_back(random_word());
        wait_for_drain();
      end
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
